// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/sha256_pkg.sv =====
// ------------------------------------------------------------------------
// sha256_pkg
// Constants and helper functions for the SHA-256 digest block.
// ------------------------------------------------------------------------
package sha256_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha256_message_digest.sv =====
// ------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 digest of a byte stream, one round unit shared over all rounds.
// ------------------------------------------------------------------------
// Feed message bytes one per transfer on s_axis (tdata = data_byte,
// tuser = has_byte); tlast closes the message and may carry a final byte
// or none. A byte that does not complete a 64-byte block is packed into
// the block words. A byte completing a block holds s_axis_tready low while
// the block loads the working words, runs the rounds and folds the
// working words into the chain. The closing transfer adds a pad step and
// one or two more compressions (two when 56 or more bytes sit in the open
// block). A closing byte that itself completes a block first runs that
// block's compression, then the pad step and one compression of the
// padding block. The eight digest words are then presented on m_axis, h0
// first, one per transfer, tlast on h7; a stalled receiver holds the block
// in that phase. The single round unit runs one round per cycle. After the
// digest the chain returns to the initial values and the next message may
// start.
module sha256_message_digest
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  chain_reg [8];
    logic [31:0]  wv_reg    [8];
    logic [31:0]  w_reg     [16];  // block words, then the schedule window
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [5:0]   round_reg;
    logic [2:0]   out_idx_reg;
    logic         final_reg;   // compressing the closing block(s)
    logic         second_reg;  // a length-only block still follows
    logic         padded_reg;  // padding already placed for this message

    logic         in_fire;
    logic [31:0]  w_cur, s0, s1, t1, t2, w_new;
    logic [31:0]  w15, w2;
    logic [31:0]  pad_w [16];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {5'd0, out_idx_reg, chain_reg[out_idx_reg]};
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

    // Schedule word and one compression round: the shared datapath.
    always_comb
    begin
        w15   = w_reg[round_reg[3:0] + 4'd1];
        w2    = w_reg[round_reg[3:0] + 4'd14];
        s0    = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1    = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        w_new = w_reg[round_reg[3:0]] + s0 + w_reg[round_reg[3:0] + 4'd9] + s1;
        w_cur = (round_reg < 6'd16) ? w_reg[round_reg[3:0]] : w_new;
        t1    = wv_reg[7] + (rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25))
              + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
              + ROUND_K[round_reg] + w_cur;
        t2    = (rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22))
              + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                 ^ (wv_reg[1] & wv_reg[2]));
    end

    // Padded block: keep the bytes taken, place 0x80, zero the tail and
    // drop in the bit length when it fits.
    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            pad_w[j] = w_reg[j];
            for (int k = 0; k < 4; k++)
            begin
                if (4 * j + k == int'(fill_reg))
                    pad_w[j][31 - 8 * k -: 8] = PAD_BYTE;
                else if (4 * j + k > int'(fill_reg))
                    pad_w[j][31 - 8 * k -: 8] = 8'd0;
            end
        end
        if (fill_reg < 6'd56)
        begin
            pad_w[14] = bits_reg[63:32];
            pad_w[15] = bits_reg[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser && fill_reg == 6'(BLOCK_BYTES - 1))
                        state_next = ST_LOAD;
                    else if (s_axis_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: state_next = (round_reg == 6'(ROUNDS - 1)) ? ST_FOLD : ST_ROUND;
            ST_FOLD:
            begin
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (!padded_reg)
                    state_next = ST_PAD;
                else if (second_reg)
                    state_next = ST_LOAD;
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready && out_idx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            final_reg   <= 1'b0;
            second_reg  <= 1'b0;
            padded_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= INIT_H[i];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tuser)
                        begin
                            // pack big-endian straight into the block words
                            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= s_axis_tdata;
                            fill_reg <= fill_reg + 6'd1;
                            bits_reg <= bits_reg + 64'd8;
                        end
                        // a block-completing byte with last pads after the fold
                        final_reg <= s_axis_tlast;
                    end
                end
                ST_PAD:
                begin
                    for (int i = 0; i < 16; i++)
                        w_reg[i] <= pad_w[i];
                    second_reg <= (fill_reg >= 6'd56);
                    padded_reg <= 1'b1;
                    fill_reg   <= '0;
                end
                ST_LOAD:
                begin
                    for (int i = 0; i < 8; i++)
                        wv_reg[i] <= chain_reg[i];
                    round_reg <= '0;
                end
                ST_ROUND:
                begin
                    if (round_reg >= 6'd16)
                        w_reg[round_reg[3:0]] <= w_new;
                    wv_reg[7] <= wv_reg[6];
                    wv_reg[6] <= wv_reg[5];
                    wv_reg[5] <= wv_reg[4];
                    wv_reg[4] <= wv_reg[3] + t1;
                    wv_reg[3] <= wv_reg[2];
                    wv_reg[2] <= wv_reg[1];
                    wv_reg[1] <= wv_reg[0];
                    wv_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + wv_reg[i];
                    if (final_reg && padded_reg && second_reg)
                    begin
                        // length-only block
                        for (int i = 0; i < 14; i++)
                            w_reg[i] <= 32'd0;
                        w_reg[14]  <= bits_reg[63:32];
                        w_reg[15]  <= bits_reg[31:0];
                        second_reg <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= INIT_H[i];
                            bits_reg   <= '0;
                            final_reg  <= 1'b0;
                            padded_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/sha256_checker.sv =====
// ------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the digest output sequence.
// ------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `ASSERT_IMPL(no_in_during_out, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `ASSERT_IMPL(last_on_seven, clk, rst_n, m_axis_tvalid,
        m_axis_tlast == (m_axis_tdata[34:32] == 3'd7))
    `ASSERT_NEXT(index_steps, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    `ASSERT_NEXT(idle_after_last, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        !m_axis_tvalid && s_axis_tready)
endmodule

bind sha256_message_digest sha256_checker u_sha256_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
